// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/qnr_pkg.sv
// ---------------------------------------------------------------------------
// qnr_pkg
// Widths, constants and stage types of the nearest-root pipeline.
// ---------------------------------------------------------------------------
package qnr_pkg;

    localparam int SQRT_CELLS = 33;
    localparam int DIV_CELLS  = 50;
    localparam int DISC_W     = 66;
    localparam int DVD_W      = 50;

    localparam logic [31:0] MISS_ROOT = 32'hFFFF_0000;

    typedef struct packed {
        logic               valid;
        logic               ok;
        logic [DISC_W-1:0]  disc;
        logic [35:0]        rem;
        logic [32:0]        root;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } qnr_sq_t;

    typedef struct packed {
        logic               valid;
        logic               ok;
        logic               neg;
        logic [DVD_W-1:0]   dvd;
        logic [31:0]        dvs;
        logic [31:0]        rem;
        logic [DVD_W-1:0]   quo;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } qnr_dv_t;

endpackage

// File: rtl/core/qnr_sqrt_cell.sv
// ---------------------------------------------------------------------------
// qnr_sqrt_cell
// One bit pair of the restoring square root, registered.
// ---------------------------------------------------------------------------
module qnr_sqrt_cell
    import qnr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  qnr_sq_t din,
    output qnr_sq_t dout
);

    qnr_sq_t    data_reg;
    qnr_sq_t    data_next;
    logic [35:0] rem_sh;
    logic [35:0] trial;

    always_comb
    begin
        data_next = din;
        rem_sh    = {din.rem[33:0], din.disc[DISC_W-1 -: 2]};
        trial     = {1'b0, din.root, 2'b01};
        data_next.disc = {din.disc[DISC_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            data_next.rem  = rem_sh - trial;
            data_next.root = {din.root[31:0], 1'b1};
        end
        else
        begin
            data_next.rem  = rem_sh;
            data_next.root = {din.root[31:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

// File: rtl/core/qnr_div_cell.sv
// ---------------------------------------------------------------------------
// qnr_div_cell
// One quotient bit of the restoring divider, registered.
// ---------------------------------------------------------------------------
module qnr_div_cell
    import qnr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  qnr_dv_t din,
    output qnr_dv_t dout
);

    qnr_dv_t     data_reg;
    qnr_dv_t     data_next;
    logic [31:0] rem_sh;

    always_comb
    begin
        data_next     = din;
        rem_sh        = {din.rem[30:0], din.dvd[DVD_W-1]};
        data_next.dvd = {din.dvd[DVD_W-2:0], 1'b0};
        if (rem_sh >= din.dvs)
        begin
            data_next.rem = rem_sh - din.dvs;
            data_next.quo = {din.quo[DVD_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem = rem_sh;
            data_next.quo = {din.quo[DVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

// File: rtl/core/quadratic_nearest_root.sv
// ---------------------------------------------------------------------------
// quadratic_nearest_root
// Smaller real root of a*t^2 + b*t + c, a hit when it lies inside [range_min, range_max].
// ---------------------------------------------------------------------------
// Takes one request per cycle while the output is not stalled and returns
// one result per request, in order, through 86 register stages: one for the
// products b*b and a*c, 33 cells of the bit-pair square root (the first one
// also forms the discriminant), one to form the numerator, 50 cells of the
// bit-serial divider and the output register.
// A stalled output holds the whole chain. All values are signed Q16.16; a
// miss gives hit low and root -65536.
module quadratic_nearest_root
    import qnr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,  // coef_a, coef_b, coef_c, range_min, range_max
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,  // root
    output logic         m_tuser   // hit
);

    logic en;

    logic                valid1_reg;
    logic signed [63:0]  bb_reg;
    logic signed [63:0]  ac_reg;
    logic signed [31:0]  a1_reg, b1_reg, lo1_reg, hi1_reg;

    logic signed [66:0]  disc;
    qnr_sq_t             sq_head;
    qnr_sq_t             sq_chain [SQRT_CELLS+1];

    logic signed [35:0]  num;
    logic [35:0]         num_mag;
    logic [31:0]         a_mag;
    qnr_sq_t             sq_last;
    qnr_dv_t             dv_head;
    qnr_dv_t             dv_head_reg;
    qnr_dv_t             dv_chain [DIV_CELLS+1];

    qnr_dv_t             dv_last;
    logic signed [50:0]  quo_s;
    logic                hit_next;
    logic                out_valid_reg;
    logic                out_hit_reg;
    logic [31:0]         out_root_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bb_reg  <= $signed(s_tdata[63:32]) * $signed(s_tdata[63:32]);
            ac_reg  <= $signed(s_tdata[31:0]) * $signed(s_tdata[95:64]);
            a1_reg  <= s_tdata[31:0];
            b1_reg  <= s_tdata[63:32];
            lo1_reg <= s_tdata[127:96];
            hi1_reg <= s_tdata[159:128];
        end
    end

    always_comb
    begin
        disc = {3'b000, bb_reg} - {ac_reg[63], ac_reg, 2'b00};
        sq_head.valid = valid1_reg;
        sq_head.ok    = (a1_reg != 32'sd0) && !disc[66];
        sq_head.disc  = disc[DISC_W-1:0];
        sq_head.rem   = '0;
        sq_head.root  = '0;
        sq_head.a     = a1_reg;
        sq_head.b     = b1_reg;
        sq_head.lo    = lo1_reg;
        sq_head.hi    = hi1_reg;
    end

    assign sq_chain[0] = sq_head;

    for (genvar i = 0; i < SQRT_CELLS; i++)
    begin : g_sqrt
        qnr_sqrt_cell u_cell
        (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .din  (sq_chain[i]),
            .dout (sq_chain[i+1])
        );
    end

    assign sq_last = sq_chain[SQRT_CELLS];

    always_comb
    begin
        if (!sq_last.a[31])
        begin
            num = -{{4{sq_last.b[31]}}, sq_last.b} - {3'b000, sq_last.root};
        end
        else
        begin
            num = -{{4{sq_last.b[31]}}, sq_last.b} + {3'b000, sq_last.root};
        end
        num_mag = num[35] ? -num : num;
        a_mag   = sq_last.a[31] ? -sq_last.a : sq_last.a;
        dv_head.valid = sq_last.valid;
        dv_head.ok    = sq_last.ok;
        dv_head.neg   = num[35] ^ sq_last.a[31];
        dv_head.dvd   = {num_mag[34:0], 15'd0};
        dv_head.dvs   = a_mag;
        dv_head.rem   = '0;
        dv_head.quo   = '0;
        dv_head.lo    = sq_last.lo;
        dv_head.hi    = sq_last.hi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_head_reg <= '0;
        end
        else if (en)
        begin
            dv_head_reg <= dv_head;
        end
    end

    assign dv_chain[0] = dv_head_reg;

    for (genvar j = 0; j < DIV_CELLS; j++)
    begin : g_div
        qnr_div_cell u_cell
        (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .din  (dv_chain[j]),
            .dout (dv_chain[j+1])
        );
    end

    assign dv_last = dv_chain[DIV_CELLS];

    always_comb
    begin
        quo_s    = dv_last.neg ? -$signed({1'b0, dv_last.quo}) : $signed({1'b0, dv_last.quo});
        hit_next = dv_last.ok
                && (quo_s >= $signed({{19{dv_last.lo[31]}}, dv_last.lo}))
                && (quo_s <= $signed({{19{dv_last.hi[31]}}, dv_last.hi}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_hit_reg  <= hit_next;
            out_root_reg <= hit_next ? quo_s[31:0] : MISS_ROOT;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_root_reg;
    assign m_tuser  = out_hit_reg;

endmodule

// File: rtl/core/qnr_checker.sv
// ---------------------------------------------------------------------------
// qnr_checker
// Port-level checks of the nearest-root pipeline.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qnr_checker
    import qnr_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [159:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [31:0]  m_tdata,
    input logic         m_tuser
);

    `ASSERT_NOW(a_miss_root, m_tvalid && !m_tuser, m_tdata == MISS_ROOT, "miss without -1 root")
    `ASSERT_NOW(a_empty_ready, !m_tvalid, s_tready, "empty output blocks requests")
    `ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `ASSERT_NOW(a_req_known, s_tvalid && s_tready, !$isunknown(s_tdata), "unknown request data")

endmodule

bind quadratic_nearest_root qnr_checker u_qnr_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

// File: sim/tb_quadratic_nearest_root.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_quadratic_nearest_root
// Self-checking regression of the nearest-root pipeline.
// ---------------------------------------------------------------------------
// Requests are queued by an initial block and driven one by one with random
// gaps. The expected hit flag and root of each request are computed from the
// coefficients with exact integer arithmetic. Results are checked in order as
// they leave the block, while the result side stalls at random.
// ---------------------------------------------------------------------------
module tb_quadratic_nearest_root;
    import qnr_pkg::*;

    typedef struct packed {
        logic signed [31:0] range_max;
        logic signed [31:0] range_min;
        logic signed [31:0] coef_c;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_a;
    } quad_req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] root;
    } root_res_t;

    localparam int PIPE_LAT    = 87;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_REQS = 1450;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic         m_tuser;

    quad_req_t pending_reqs[$];
    root_res_t expected_roots[$];
    int        errors;
    int        cycles;
    int        send_gap;
    int        stall_len;
    int        hits_seen;
    int        results_seen;
    bit        all_queued;

    quadratic_nearest_root dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [32:0] sqrt_floor(logic [65:0] d);
        logic [32:0] r;
        logic [67:0] trial;
        r = '0;
        for (int k = 32; k >= 0; k--)
        begin
            trial = {35'd0, r | (33'd1 << k)};
            if (trial * trial <= {2'b00, d})
                r = r | (33'd1 << k);
        end
        return r;
    endfunction

    function automatic logic signed [63:0] scaled_quotient(logic signed [63:0] num,
                                                           logic signed [63:0] den);
        logic signed [63:0] q;
        q = (num * 64'sd32768) / den;
        return q;
    endfunction

    function automatic root_res_t nearest_root(quad_req_t r);
        root_res_t res;
        logic signed [67:0] disc;
        logic signed [63:0] s, r1, r2, rmin;
        res.hit  = 1'b0;
        res.root = MISS_ROOT;
        if (r.coef_a != 0)
        begin
            disc = 68'(r.coef_b) * 68'(r.coef_b) - 68'sd4 * 68'(r.coef_a) * 68'(r.coef_c);
            if (disc >= 0)
            begin
                s    = 64'(sqrt_floor(disc[65:0]));
                r1   = scaled_quotient(-64'(r.coef_b) - s, 64'(r.coef_a));
                r2   = scaled_quotient(-64'(r.coef_b) + s, 64'(r.coef_a));
                rmin = (r1 < r2) ? r1 : r2;
                if (rmin >= 64'(r.range_min) && rmin <= 64'(r.range_max))
                begin
                    res.hit  = 1'b1;
                    res.root = rmin[31:0];
                end
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 4)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            default: return $urandom;
        endcase
    endfunction

    task automatic add_req(logic signed [31:0] a, logic signed [31:0] b,
                           logic signed [31:0] c, logic signed [31:0] lo,
                           logic signed [31:0] hi);
        quad_req_t r;
        r.coef_a    = a;
        r.coef_b    = b;
        r.coef_c    = c;
        r.range_min = lo;
        r.range_max = hi;
        pending_reqs.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    initial
    begin
        logic signed [31:0] r1, r2, a, lo, hi;
        errors     = 0;
        all_queued = 0;
        // t^2 - 3t + 2: roots 1 and 2
        add_req(32'sh10000, -32'sh30000, 32'sh20000, 32'sh0, 32'sh40000);
        add_req(32'sh10000, -32'sh30000, 32'sh20000, 32'sh18000, 32'sh40000);
        // zero a, negative discriminant, empty window, double root
        add_req(32'sh0, 32'sh10000, 32'sh10000, 32'sh80000000, 32'sh7FFFFFFF);
        add_req(32'sh10000, 32'sh0, 32'sh10000, 32'sh80000000, 32'sh7FFFFFFF);
        add_req(32'sh10000, -32'sh30000, 32'sh20000, 32'sh40000, 32'sh0);
        add_req(32'sh10000, -32'sh20000, 32'sh10000, 32'sh80000000, 32'sh7FFFFFFF);
        // root at minus one inside the window
        add_req(32'sh10000, 32'sh20000, 32'sh10000, -32'sh20000, 32'sh0);
        add_req(-32'sh10000, 32'sh30000, -32'sh20000, 32'sh80000000, 32'sh7FFFFFFF);
        add_req(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
        add_req(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF);
        add_req(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF);
        add_req(32'sh1, 32'sh7FFFFFFF, 32'sh0, 32'sh80000000, 32'sh7FFFFFFF);
        add_req(-32'sh1, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
        add_req(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
        add_req(32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF);
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                // real roots built from chosen values so that hits are common
                r1 = 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
                r2 = 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
                a  = 32'($signed($urandom_range(1, 1 << 16)));
                if ($urandom_range(0, 1))
                    a = -a;
                lo = ($urandom_range(0, 3) == 0) ? rand_word() : r1 - $urandom_range(0, 1 << 16);
                hi = ($urandom_range(0, 3) == 0) ? rand_word() : r1 + $urandom_range(0, 9 << 16);
                add_req(a,
                        32'((-64'(a) * (64'(r1) + 64'(r2))) >>> 16),
                        32'((((64'(a) * 64'(r1)) >>> 16) * 64'(r2)) >>> 16),
                        lo, hi);
            end
            else
                add_req(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
        end
        all_queued = 1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                expected_roots.push_back(nearest_root(quad_req_t'(s_tdata)));
            if (send_gap > 0 || pending_reqs.size() == 0)
            begin
                s_tvalid <= 1'b0;
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_reqs.pop_front();
                send_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        root_res_t want;
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            stall_len    <= 0;
            hits_seen    <= 0;
            results_seen <= 0;
            cycles       <= 0;
        end
        else
        begin
            cycles <= cycles + 1;
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_roots.size() == 0)
                    report_mismatch("unexpected result", m_tdata, '0);
                else
                begin
                    want = expected_roots.pop_front();
                    if (m_tuser)
                        hits_seen <= hits_seen + 1;
                    if (m_tuser !== want.hit)
                        report_mismatch("hit", 32'(m_tuser), 32'(want.hit));
                    if (m_tdata !== want.root)
                        report_mismatch("root", m_tdata, want.root);
                end
            end
            if (stall_len > 0)
            begin
                m_tready  <= 1'b0;
                stall_len <= stall_len - 1;
            end
            else
            begin
                m_tready  <= 1'b1;
                stall_len <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (!(all_queued && pending_reqs.size() == 0 && !s_tvalid
                 && expected_roots.size() == 0) && cycles < CYCLE_LIMIT)
            @(posedge clk);
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_roots.size());
            $display("quadratic_nearest_root regression: fail");
            $finish;
        end
        else
        begin
            repeat (2 * PIPE_LAT) @(posedge clk);
            $display("checked %0d results, %0d of them hits, with random gaps and stalls",
                     results_seen, hits_seen);
            if (errors == 0)
                $display("quadratic_nearest_root regression: pass");
            else
                $display("quadratic_nearest_root regression: fail");
            $finish;
        end
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/qnr_pkg.sv
rtl/core/qnr_sqrt_cell.sv
rtl/core/qnr_div_cell.sv
rtl/core/quadratic_nearest_root.sv
rtl/core/qnr_checker.sv
sim/tb_quadratic_nearest_root.sv
